// ===== sv/assert_macros.svh =====
// Assertion macros used by the pip_chk checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define PIP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PIP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pip_pkg.sv =====
`timescale 1ns / 1ps

package pip_pkg;

  localparam int unsigned COORD_BITS       = 24;
  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MIN_VERTICES     = 3;
  localparam int unsigned TOL_W            = 12;
  localparam logic [TOL_W-1:0] TOL_RESET   = 12'd328;
  localparam int unsigned Q_SHIFT          = 12;
  localparam int unsigned COUNT_W          = 7;

  localparam int unsigned DIFF_W   = COORD_BITS + 1;
  localparam int unsigned OPND_W   = 2 * DIFF_W + 3;
  localparam int unsigned N_DIGITS = 4;
  localparam int unsigned DIGIT_W  = (OPND_W - 1 + N_DIGITS - 1) / N_DIGITS;
  localparam int unsigned MAG_W    = DIGIT_W * N_DIGITS;
  localparam int unsigned ACC_W    = 2 * MAG_W + 2;
  localparam int unsigned VTX_W    = 2 * COORD_BITS;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } pip_cmd_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } pip_in_t;

  typedef struct packed {
    logic               inside_res;
    logic               on_edge;
    logic [COUNT_W-1:0] vertex_count;
    logic               overflow;
  } pip_out_t;

  typedef struct packed {
    logic                     start;
    logic                     neg;
    logic signed [OPND_W-1:0] opa;
    logic signed [OPND_W-1:0] opb;
    logic signed [ACC_W-1:0]  init;
  } pip_mul_req_t;

  typedef enum logic [3:0] {
    OP_E2, OP_LX, OP_LY, OP_SX, OP_SY, OP_TX, OP_TY,
    OP_CX, OP_CY, OP_LO, OP_HI, OP_QS, OP_QL
  } pip_op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_E2, ST_RDLAST, ST_PREV, ST_RD, ST_DIFF, ST_OPS, ST_EVAL
  } pip_state_e;

endpackage

// ===== sv/point_in_polygon_edge_tolerant.sv =====
`timescale 1ns / 1ps

// Point-in-polygon unit with an on-edge tolerance. Clear and append commands produce their
// registered result transfer in the cycle after they are accepted. A query on a polygon of
// n >= 3 vertices needs twelve products per edge on the single shared multiplier, which
// handles 13 multiplier bits per cycle, besides the steps for the vertex read, the
// differences and the decision. A query on fewer than three vertices answers outside. The
// input is stalled while a query runs. Coordinates are signed Q12.12; the user must write
// edge_tolerance through cfg_we_i and cfg_wdata_i only while the unit is idle, and the
// unit itself does not enforce this.
module point_in_polygon_edge_tolerant
  import pip_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
)
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pip_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pip_out_t         out_data_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);

  pip_state_e state_q, state_d;
  pip_op_e    op_q, op_d;
  logic       run_q, run_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [TOL_W-1:0] tol_q, tol_d;
  logic       near_q, near_d;
  logic       odd_q, odd_d;
  logic       out_valid_q, out_valid_d;
  pip_out_t   out_q, out_d;

  logic signed [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic signed [COORD_BITS-1:0] bx_q, bx_d, by_q, by_d;
  logic signed [DIFF_W-1:0] dx_q, dx_d, dy_q, dy_d, ex_q, ex_d, ey_q, ey_d;
  logic       cren_q, cren_d;
  logic signed [ACC_W-1:0] e2_q, e2_d, l_q, l_d, s_q, s_d, t_q, t_d;
  logic signed [ACC_W-1:0] c_q, c_d, lo_q, lo_d, hi_q, hi_d, qd_q, qd_d;

  logic in_accept, full, long_query, last_edge;
  logic [CNT_W-1:0] last_idx;
  logic signed [COORD_BITS-1:0] ax, ay;
  logic signed [OPND_W-1:0] tol_op;
  logic near_now, cross_now, small_edge;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_raddr;
  logic [VTX_W-1:0]  mem_rdata;

  logic                    mul_start;
  pip_mul_req_t            mul_req;
  logic                    mul_done;
  logic signed [ACC_W-1:0] mul_res;

  assign in_stall_o = !(state_q == ST_IDLE && (!out_valid_q || !out_stall_i));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = cnt_q == CNT_W'(MAX_VERTICES);
  assign long_query = in_data_i.command == CMD_QUERY && cnt_q >= CNT_W'(MIN_VERTICES);
  assign last_idx   = cnt_q - CNT_W'(1);
  assign last_edge  = idx_q == last_idx;
  assign ax         = mem_rdata[COORD_BITS-1:0];
  assign ay         = mem_rdata[VTX_W-1:COORD_BITS];
  assign tol_op     = OPND_W'(tol_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && long_query) begin
          state_d = ST_E2;
        end
      end
      ST_E2: begin
        if (mul_done) begin
          state_d = ST_RDLAST;
        end
      end
      ST_RDLAST: state_d = ST_PREV;
      ST_PREV:   state_d = ST_RD;
      ST_RD:     state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_OPS;
      ST_OPS: begin
        if (mul_done && op_q == OP_QL) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = last_edge ? ST_IDLE : ST_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_raddr = idx_q[ADDR_W-1:0];
    mul_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        mem_we = in_accept && in_data_i.command == CMD_APPEND && !full;
      end
      ST_E2, ST_OPS: begin
        mul_start = !run_q;
      end
      ST_RDLAST: begin
        mem_raddr = last_idx[ADDR_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req.start = mul_start;
    mul_req.opa   = '0;
    mul_req.opb   = '0;
    mul_req.init  = '0;
    mul_req.neg   = 1'b0;
    case (op_q)
      OP_E2: begin
        mul_req.opa = tol_op;
        mul_req.opb = tol_op;
      end
      OP_LX: begin
        mul_req.opa = OPND_W'(ex_q);
        mul_req.opb = OPND_W'(ex_q);
      end
      OP_LY: begin
        mul_req.opa  = OPND_W'(ey_q);
        mul_req.opb  = OPND_W'(ey_q);
        mul_req.init = l_q;
      end
      OP_SX: begin
        mul_req.opa  = OPND_W'(dx_q);
        mul_req.opb  = OPND_W'(dx_q);
        mul_req.init = -e2_q;
      end
      OP_SY: begin
        mul_req.opa  = OPND_W'(dy_q);
        mul_req.opb  = OPND_W'(dy_q);
        mul_req.init = s_q;
      end
      OP_TX: begin
        mul_req.opa = OPND_W'(dx_q);
        mul_req.opb = OPND_W'(ex_q);
      end
      OP_TY: begin
        mul_req.opa  = OPND_W'(dy_q);
        mul_req.opb  = OPND_W'(ey_q);
        mul_req.init = t_q;
      end
      OP_CX: begin
        mul_req.opa = OPND_W'(dx_q);
        mul_req.opb = OPND_W'(ey_q);
      end
      OP_CY: begin
        mul_req.opa  = OPND_W'(dy_q);
        mul_req.opb  = OPND_W'(ex_q);
        mul_req.init = c_q;
        mul_req.neg  = 1'b1;
      end
      OP_LO: begin
        mul_req.opa  = tol_op;
        mul_req.opb  = OPND_W'(l_q);
        mul_req.init = t_q <<< Q_SHIFT;
      end
      OP_HI: begin
        mul_req.opa  = tol_op;
        mul_req.opb  = OPND_W'(l_q);
        mul_req.init = (t_q - l_q) <<< Q_SHIFT;
        mul_req.neg  = 1'b1;
      end
      OP_QS: begin
        mul_req.opa = OPND_W'(c_q);
        mul_req.opb = OPND_W'(c_q);
      end
      OP_QL: begin
        mul_req.opa  = OPND_W'(e2_q);
        mul_req.opb  = OPND_W'(l_q);
        mul_req.init = qd_q;
        mul_req.neg  = 1'b1;
      end
      default: begin
        mul_req.neg = 1'b0;
      end
    endcase
  end

  // Edge decision from the finished products.
  always_comb begin
    small_edge = (l_q < e2_q) || (l_q == '0);
    if (small_edge) begin
      near_now = s_q[ACC_W-1] || (s_q == '0);
    end else begin
      near_now = !lo_q[ACC_W-1] && (hi_q[ACC_W-1] || (hi_q == '0)) &&
                 (qd_q[ACC_W-1] || (qd_q == '0));
    end
    if (!ey_q[DIFF_W-1] && ey_q != '0) begin
      cross_now = cren_q && c_q[ACC_W-1];
    end else begin
      cross_now = cren_q && !c_q[ACC_W-1] && c_q != '0;
    end
  end

  // Datapath.
  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    op_d        = op_q;
    run_d       = run_q;
    tol_d       = cfg_we_i ? cfg_wdata_i : tol_q;
    near_d      = near_q;
    odd_d       = odd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    px_d = px_q;
    py_d = py_q;
    bx_d = bx_q;
    by_d = by_q;
    dx_d = dx_q;
    dy_d = dy_q;
    ex_d = ex_q;
    ey_d = ey_q;
    cren_d = cren_q;
    e2_d = e2_q;
    l_d  = l_q;
    s_d  = s_q;
    t_d  = t_q;
    c_d  = c_q;
    lo_d = lo_q;
    hi_d = hi_q;
    qd_d = qd_q;

    if (mul_req.start) begin
      run_d = 1'b1;
    end
    if (mul_done) begin
      run_d = 1'b0;
      op_d  = pip_op_e'(op_q + 1'b1);
      case (op_q)
        OP_E2:        e2_d = mul_res;
        OP_LX, OP_LY: l_d  = mul_res;
        OP_SX, OP_SY: s_d  = mul_res;
        OP_TX, OP_TY: t_d  = mul_res;
        OP_CX, OP_CY: c_d  = mul_res;
        OP_LO:        lo_d = mul_res;
        OP_HI:        hi_d = mul_res;
        OP_QS, OP_QL: qd_d = mul_res;
        default:      run_d = 1'b0;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          px_d   = in_data_i.coord_x;
          py_d   = in_data_i.coord_y;
          idx_d  = '0;
          op_d   = OP_E2;
          near_d = 1'b0;
          odd_d  = 1'b0;
          out_d  = '0;
          case (in_data_i.command)
            CMD_CLEAR: begin
              cnt_d = '0;
            end
            CMD_APPEND: begin
              if (full) begin
                out_d.overflow = 1'b1;
              end else begin
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            default: begin
              cnt_d = cnt_q;
            end
          endcase
          out_d.vertex_count = COUNT_W'(cnt_d);
          out_valid_d = !long_query;
        end
      end
      ST_PREV: begin
        bx_d = ax;
        by_d = ay;
      end
      ST_DIFF: begin
        ex_d   = DIFF_W'(bx_q) - DIFF_W'(ax);
        ey_d   = DIFF_W'(by_q) - DIFF_W'(ay);
        dx_d   = DIFF_W'(px_q) - DIFF_W'(ax);
        dy_d   = DIFF_W'(py_q) - DIFF_W'(ay);
        cren_d = (ay > py_q) != (by_q > py_q);
        bx_d   = ax;
        by_d   = ay;
        op_d   = OP_LX;
      end
      ST_EVAL: begin
        near_d = near_q || near_now;
        odd_d  = odd_q ^ cross_now;
        idx_d  = idx_q + CNT_W'(1);
        if (last_edge) begin
          out_valid_d        = 1'b1;
          out_d.inside_res   = near_d || odd_d;
          out_d.on_edge      = near_d;
          out_d.vertex_count = COUNT_W'(cnt_q);
          out_d.overflow     = 1'b0;
        end
      end
      default: begin
        cren_d = cren_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_E2;
      run_q       <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      tol_q       <= TOL_RESET;
      near_q      <= 1'b0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      run_q       <= run_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      tol_q       <= tol_d;
      near_q      <= near_d;
      odd_q       <= odd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    px_q   <= px_d;
    py_q   <= py_d;
    bx_q   <= bx_d;
    by_q   <= by_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    cren_q <= cren_d;
    e2_q   <= e2_d;
    l_q    <= l_d;
    s_q    <= s_d;
    t_q    <= t_d;
    c_q    <= c_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    qd_q   <= qd_d;
  end

  pip_vstore #(
    .DEPTH  (MAX_VERTICES),
    .ADDR_W (ADDR_W)
  ) u_vstore (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i ({in_data_i.coord_y, in_data_i.coord_x}),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pip_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mul_req),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/pip_mul.sv =====
`timescale 1ns / 1ps

module pip_mul
  import pip_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pip_mul_req_t            req_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] result_o
);

  localparam int unsigned K_W = $clog2(N_DIGITS);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [MAG_W-1:0] mag_a_q, mag_a_d;
  logic [MAG_W-1:0] mag_b_q, mag_b_d;
  logic             sub_q, sub_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [OPND_W-1:0] a_abs, b_abs;
  logic [DIGIT_W-1:0] digit;
  logic [MAG_W+DIGIT_W-1:0] pp;
  logic [ACC_W-1:0] pp_sh;

  always_comb begin
    a_abs   = req_i.opa[OPND_W-1] ? (~req_i.opa + 1'b1) : req_i.opa;
    b_abs   = req_i.opb[OPND_W-1] ? (~req_i.opb + 1'b1) : req_i.opb;
    digit   = mag_b_q[k_q*DIGIT_W +: DIGIT_W];
    pp      = mag_a_q * digit;
    pp_sh   = ACC_W'(pp) << (k_q * DIGIT_W);
    busy_d  = busy_q;
    done_d  = 1'b0;
    k_d     = k_q;
    mag_a_d = mag_a_q;
    mag_b_d = mag_b_q;
    sub_d   = sub_q;
    acc_d   = acc_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      k_d     = '0;
      mag_a_d = MAG_W'(a_abs);
      mag_b_d = MAG_W'(b_abs);
      sub_d   = req_i.neg ^ req_i.opa[OPND_W-1] ^ req_i.opb[OPND_W-1];
      acc_d   = req_i.init;
    end else if (busy_q) begin
      acc_d = sub_q ? (acc_q - $signed(pp_sh)) : (acc_q + $signed(pp_sh));
      k_d   = k_q + 1'b1;
      if (k_q == K_W'(N_DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
    sub_q   <= sub_d;
    acc_q   <= acc_d;
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

// ===== sv/pip_vstore.sv =====
`timescale 1ns / 1ps

module pip_vstore
  import pip_pkg::*;
#(
  parameter int unsigned DEPTH  = MAX_VERTICES_DEF,
  parameter int unsigned ADDR_W = $clog2(MAX_VERTICES_DEF)
)
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [VTX_W-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [VTX_W-1:0]  rdata_o
);

  logic [VTX_W-1:0] mem_q [DEPTH];
  logic [VTX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pip_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pip_chk
  import pip_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
)
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input pip_in_t          in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input pip_out_t         out_data_o
);

  `PIP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result transfer changed")
  `PIP_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")
  `PIP_ASSERT(a_edge_inside, clk_i, rst_ni, out_valid_o && out_data_o.on_edge |-> out_data_o.inside_res, "on-edge result not inside")
  `PIP_ASSERT(a_ovf_full, clk_i, rst_ni, out_valid_o && out_data_o.overflow |-> out_data_o.vertex_count == COUNT_W'(MAX_VERTICES) && !out_data_o.inside_res && !out_data_o.on_edge, "overflow with store not full")
  `PIP_ASSERT(a_short_cmd, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.command != CMD_QUERY |=> out_valid_o, "no result after a clear or append transfer")

endmodule

bind point_in_polygon_edge_tolerant pip_chk #(
  .MAX_VERTICES (MAX_VERTICES)
) u_pip_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== bench/pip_checker.sv =====
`timescale 1ns / 1ps

module pip_checker
  import pip_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  pip_in_t          in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  pip_out_t         out_data_i,
  output int               errors_o,
  output int               pending_o,
  output int               queries_o,
  output int               insides_o,
  output int               edges_o,
  output int               overflows_o
);

  localparam int unsigned NV = MAX_VERTICES_DEF;

  typedef logic signed [159:0] wide_t;

  logic signed [COORD_BITS-1:0] poly_x [NV];
  logic signed [COORD_BITS-1:0] poly_y [NV];
  int unsigned                  poly_count;
  logic [TOL_W-1:0]             tolerance;
  pip_out_t                     expected_results [$];
  int                           errors, queries, insides, edges, overflows;

  assign errors_o    = errors;
  assign pending_o   = expected_results.size();
  assign queries_o   = queries;
  assign insides_o   = insides;
  assign edges_o     = edges;
  assign overflows_o = overflows;

  function automatic logic point_near_edge(wide_t px, wide_t py, wide_t ax, wide_t ay,
                                           wide_t bx, wide_t by, wide_t e);
    wide_t ex, ey, dx, dy, len2, e2, dots, cr;
    ex   = bx - ax;
    ey   = by - ay;
    dx   = px - ax;
    dy   = py - ay;
    len2 = ex * ex + ey * ey;
    e2   = e * e;
    if (len2 < e2 || len2 == 0) begin
      return (dx * dx + dy * dy) <= e2;
    end
    dots = (dx * ex + dy * ey) * 4096;
    if (dots < -(e * len2)) begin
      return 1'b0;
    end
    if (dots > (e + 4096) * len2) begin
      return 1'b0;
    end
    cr = dx * ey - dy * ex;
    return (cr * cr) <= (e2 * len2);
  endfunction

  function automatic logic ray_crosses(wide_t px, wide_t py, wide_t ax, wide_t ay,
                                       wide_t bx, wide_t by);
    wide_t den, lhs, rhs;
    if ((ay > py) == (by > py)) begin
      return 1'b0;
    end
    den = by - ay;
    lhs = (px - ax) * den;
    rhs = (bx - ax) * (py - ay);
    return (den > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  function automatic pip_out_t polygon_step(pip_in_t it);
    pip_out_t r;
    wide_t    px, py, ax, ay, bx, by, e;
    int       i, j;
    logic     odd;
    r  = '0;
    px = it.coord_x;
    py = it.coord_y;
    e  = {148'd0, tolerance};
    case (it.command)
      CMD_CLEAR: poly_count = 0;
      CMD_APPEND: begin
        if (poly_count >= NV) begin
          r.overflow = 1'b1;
        end else begin
          poly_x[poly_count] = it.coord_x;
          poly_y[poly_count] = it.coord_y;
          poly_count++;
        end
      end
      CMD_QUERY: begin
        if (poly_count >= MIN_VERTICES) begin
          j = poly_count - 1;
          for (i = 0; i < poly_count; i++) begin
            ax = poly_x[i];
            ay = poly_y[i];
            bx = poly_x[j];
            by = poly_y[j];
            if (!r.on_edge && point_near_edge(px, py, ax, ay, bx, by, e)) begin
              r.on_edge = 1'b1;
            end
            j = i;
          end
          if (r.on_edge) begin
            r.inside_res = 1'b1;
          end else begin
            odd = 1'b0;
            j = poly_count - 1;
            for (i = 0; i < poly_count; i++) begin
              ax = poly_x[i];
              ay = poly_y[i];
              bx = poly_x[j];
              by = poly_y[j];
              if (ray_crosses(px, py, ax, ay, bx, by)) begin
                odd = ~odd;
              end
              j = i;
            end
            r.inside_res = odd;
          end
        end
      end
      default: ;
    endcase
    r.vertex_count = poly_count[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pip_out_t exp_r;
    if (!rst_ni) begin
      poly_count = 0;
      tolerance  = TOL_RESET;
      expected_results.delete();
      errors    = 0;
      queries   = 0;
      insides   = 0;
      edges     = 0;
      overflows = 0;
    end else begin
      if (cfg_we_i) begin
        tolerance = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        exp_r = polygon_step(in_data_i);
        if (in_data_i.command == CMD_QUERY) queries++;
        if (exp_r.inside_res) insides++;
        if (exp_r.on_edge) edges++;
        if (exp_r.overflow) overflows++;
        expected_results = {expected_results, exp_r};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result transfer %p", out_data_i);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_i.inside_res !== exp_r.inside_res ||
              out_data_i.on_edge !== exp_r.on_edge ||
              out_data_i.vertex_count !== exp_r.vertex_count ||
              out_data_i.overflow !== exp_r.overflow) begin
            errors++;
            if (errors <= 10) begin
              $display("ERROR: expected %p, got %p", exp_r, out_data_i);
            end
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_point_in_polygon_edge_tolerant.sv =====
`timescale 1ns / 1ps

module tb_point_in_polygon_edge_tolerant;
  import pip_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [TOL_W-1:0] cfg_wdata;
  logic             in_valid, in_stall, out_valid, out_stall;
  pip_in_t          in_data;
  pip_out_t         out_data;
  logic             in_acc, out_acc;
  int               errors, pending, queries, insides, edges, overflows;
  int               sent, received, settings;
  logic             quick_send;

  point_in_polygon_edge_tolerant u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pip_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .queries_o   (queries),
    .insides_o   (insides),
    .edges_o     (edges),
    .overflows_o (overflows)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    in_acc  <= in_valid & ~in_stall;
    out_acc <= out_valid & ~out_stall;
  end

  initial begin
    #30000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_item(logic [1:0] cmd, logic [COORD_BITS-1:0] x,
                           logic [COORD_BITS-1:0] y);
    int gap;
    gap = quick_send ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, coord_x: x, coord_y: y};
    do @(negedge clk_i); while (!in_acc);
    sent++;
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] tol);
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (10) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= tol;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [COORD_BITS-1:0] near_coord(int base, int span);
    return COORD_BITS'(base + $urandom_range(0, 2 * span) - span);
  endfunction

  task automatic random_polygons(int target);
    int n, nq, span, cx, cy, k, pick, tol_span;
    int vx [70];
    int vy [70];
    while (sent < target) begin
      quick_send = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_item(2'($urandom_range(0, 3)), COORD_BITS'($urandom), COORD_BITS'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: span = 1 << 8;
          1: span = 1 << 14;
          2: span = 1 << 20;
          default: span = (1 << 23) - 1;
        endcase
        cx = (span == (1 << 23) - 1) ? 0 :
             int'($signed(near_coord(0, (1 << 23) - 1 - span)));
        cy = (span == (1 << 23) - 1) ? 0 :
             int'($signed(near_coord(0, (1 << 23) - 1 - span)));
        n = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 9);
        nq = (n > 20) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        if ($urandom_range(0, 7) != 0) begin
          send_item(CMD_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
        for (k = 0; k < n; k++) begin
          vx[k] = int'($signed(near_coord(cx, span)));
          vy[k] = int'($signed(near_coord(cy, span)));
          if (k > 0 && $urandom_range(0, 19) == 0) begin
            vx[k] = vx[k - 1];
            vy[k] = vy[k - 1];
          end
          send_item(CMD_APPEND, COORD_BITS'(vx[k]), COORD_BITS'(vy[k]));
        end
        tol_span = $urandom_range(0, 600);
        for (k = 0; k < nq; k++) begin
          pick = $urandom_range(0, n - 1);
          case ($urandom_range(0, 3))
            0: send_item(CMD_QUERY, near_coord(vx[pick], tol_span),
                         near_coord(vy[pick], tol_span));
            1: send_item(CMD_QUERY,
                         near_coord((vx[pick] + vx[(pick + 1) % n]) / 2, tol_span),
                         near_coord((vy[pick] + vy[(pick + 1) % n]) / 2, tol_span));
            default: send_item(CMD_QUERY, near_coord(cx, span), near_coord(cy, span));
          endcase
        end
      end
    end
  endtask

  initial begin
    int w;
    out_stall <= 1'b0;
    received = 0;
    @(posedge rst_ni);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (received == 300) w = 800;
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(negedge clk_i); while (!out_acc);
      received++;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    sent       = 0;
    settings   = 0;
    quick_send = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_tolerance('0);
    send_item(CMD_QUERY, 24'd0, 24'd0);
    send_item(CMD_APPEND, 24'd0, 24'd0);
    send_item(CMD_APPEND, 24'd16384, 24'd0);
    send_item(CMD_QUERY, 24'd8192, 24'd0);
    send_item(CMD_APPEND, 24'd16384, 24'd16384);
    send_item(CMD_APPEND, 24'd0, 24'd16384);
    send_item(CMD_QUERY, 24'd8192, 24'd8192);
    send_item(CMD_QUERY, 24'd20000, 24'd8192);
    send_item(CMD_QUERY, 24'd16384, 24'd8192);
    send_item(CMD_QUERY, 24'd0, 24'd0);
    send_item(CMD_UNUSED, 24'hFFFFFF, 24'hFFFFFF);
    send_item(CMD_CLEAR, 24'h000000, 24'hFFFFFF);
    send_item(CMD_APPEND, 24'h7FFFFF, 24'h7FFFFF);
    send_item(CMD_APPEND, 24'h800000, 24'h800000);
    send_item(CMD_APPEND, 24'h7FFFFF, 24'h800000);
    send_item(CMD_APPEND, 24'h7FFFFF, 24'h800000);
    send_item(CMD_QUERY, 24'h7FFFFF, 24'h800000);
    send_item(CMD_QUERY, 24'h800000, 24'h7FFFFF);
    send_item(CMD_QUERY, 24'h000000, 24'h000000);
    send_item(CMD_QUERY, 24'h000001, 24'hFFFFFF);

    set_tolerance(12'd4095);
    random_polygons(220);
    set_tolerance(TOL_RESET);
    random_polygons(420);
    set_tolerance(12'd1);
    random_polygons(620);
    set_tolerance(TOL_W'($urandom_range(0, 4095)));
    random_polygons(820);
    set_tolerance('0);
    random_polygons(1020);

    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (20) @(negedge clk_i);
    $display("Sent %0d transfers under %0d tolerance settings: %0d queries, %0d inside,",
             sent, settings, queries, insides);
    $display("%0d within tolerance of an edge, %0d appends dropped on a full store.",
             edges, overflows);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
